[sv/ieee_double_legacy_float_convert_unit_assert.svh]
// Assertion macros for the double and legacy float converter.
`ifndef IEEE_DOUBLE_LEGACY_FLOAT_CONVERT_UNIT_ASSERT_SVH
`define IEEE_DOUBLE_LEGACY_FLOAT_CONVERT_UNIT_ASSERT_SVH
// Checks that an implication holds at every clock edge outside reset.
`define DLF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Checks that a condition holds in the cycle after a trigger.
`define DLF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/dlf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dlf_pkg;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_UNF  = 2'd2;
  localparam logic [1:0] ST_NAN  = 2'd3;
  localparam logic [47:0] POS_MAX  = 48'hFEFFFFFFFFFF;
  localparam logic [47:0] NEG_MAX  = 48'hFF0000000000;
  localparam logic [47:0] NEG_TINY = 48'h017FFFFFFFFF;

  typedef struct packed {
    logic        mode;
    logic        neg;
    logic [10:0] ef;
    logic [51:0] f;
    logic [40:0] wm;
    logic [6:0]  wex;
  } dlf_s1_t;

  typedef struct packed {
    logic        mode;
    logic        done;
    logic [63:0] res;
    logic [1:0]  status;
    logic        neg;
    logic [12:0] ex;
    logic [40:0] word;
    logic        inc;
    logic        sign;
    logic [40:0] a;
    logic [6:0]  wex;
  } dlf_s2_t;

  typedef struct packed {
    logic [63:0] res;
    logic [1:0]  status;
  } dlf_out_t;

  function automatic logic [5:0] dlf_top_bit(input logic [40:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 41; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction
endpackage
`default_nettype wire

[sv/dlf_stage_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
module dlf_stage_decode import dlf_pkg::*; (
  input  wire logic        mode,
  input  wire logic [63:0] operand,
  output dlf_s1_t          s1
);
  always_comb begin
    s1.mode = mode;
    s1.neg  = operand[63];
    s1.ef   = operand[62:52];
    s1.f    = operand[51:0];
    s1.wm   = operand[40:0];
    s1.wex  = operand[47:41];
  end
endmodule
`default_nettype wire

[sv/dlf_stage_round.sv]
`timescale 1ns / 1ps
`default_nettype none
module dlf_stage_round import dlf_pkg::*; (
  input  wire dlf_s1_t s1,
  output dlf_s2_t      s2
);
  logic [52:0] m53;
  logic [53:0] t;
  always_comb begin
    m53 = {1'b1, s1.f};
    t   = 54'(54'h20000000000000 - {1'b0, m53});
    s2 = '0;
    s2.mode = s1.mode;
    s2.neg  = s1.neg;
    s2.ex   = 13'({2'b0, s1.ef}) - 13'd1022;
    s2.wex  = s1.wex;
    if (s1.mode) begin
      s2.sign = s1.wm[40];
      s2.a    = s1.wm[40] ? 41'(42'h20000000000 - {1'b0, s1.wm}) : s1.wm;
      s2.done = (s1.wm == '0);
    end else if (s1.ef == 11'h7FF) begin
      s2.done = 1'b1;
      if (s1.f != '0) s2.status = ST_NAN;
      else begin
        s2.status = ST_OVF;
        s2.res = {16'h0, s1.neg ? NEG_MAX : POS_MAX};
      end
    end else if (s1.ef == '0) begin
      s2.done = 1'b1;
      if (s1.f != '0) s2.status = ST_UNF;
    end else if (!s1.neg) begin
      s2.word = {1'b0, m53[52:13]};
      s2.inc  = m53[12];
    end else if (s1.f == '0) begin
      if (s1.ef == 11'd958) begin
        s2.done = 1'b1;
        s2.res  = {16'h0, NEG_TINY};
      end else begin
        s2.ex = 13'({2'b0, s1.ef}) - 13'd1023;
      end
    end else begin
      s2.word = {1'b0, t[52:13]};
      s2.inc  = t[12] && (t[11:0] != '0);
    end
  end
endmodule
`default_nettype wire

[sv/dlf_stage_pack.sv]
`timescale 1ns / 1ps
`default_nettype none
module dlf_stage_pack import dlf_pkg::*; (
  input  wire dlf_s2_t s2,
  output dlf_out_t     o
);
  logic [40:0] w;
  logic [12:0] ex;
  logic [5:0]  p;
  logic [10:0] be;
  logic [104:0] sh;
  always_comb begin
    w  = 41'(s2.word + {40'h0, s2.inc});
    ex = s2.ex;
    p  = dlf_top_bit(s2.a);
    be = 11'({5'h0, p} + {4'h0, s2.wex} + 11'd919);
    sh = 105'({64'h0, s2.a} << (7'd52 - {1'b0, p}));
    o = '0;
    if (s2.done) begin
      o.res = s2.res;
      o.status = s2.status;
    end else if (s2.mode) begin
      o.res = {s2.sign, be, sh[51:0]};
    end else begin
      if (!s2.neg && w[40]) begin
        w  = {1'b0, w[40:1]};
        ex = ex + 13'd1;
      end
      if (s2.neg) w[40] = 1'b1;
      if (!ex[12] && ex > 13'd63) begin
        o.status = ST_OVF;
        o.res = {16'h0, s2.neg ? NEG_MAX : POS_MAX};
      end else if (ex[12] && ex < 13'h1FC0) begin
        o.status = ST_UNF;
      end else begin
        o.res = {16'h0, 7'(ex + 13'd64), w};
      end
    end
  end
endmodule
`default_nettype wire

[sv/ieee_double_legacy_float_convert_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Converts IEEE doubles to 48-bit legacy float words (mode 0) and back (mode 1), one
// operand per cycle while the output is not stalled, through decode, round and pack
// register stages; a stall freezes all stages together, and a full output stage
// still accepts while its own slot is being drained.
`include "ieee_double_legacy_float_convert_unit_assert.svh"
module ieee_double_legacy_float_convert_unit import dlf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // operand
  input  wire logic        in_tuser,  // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata, // result
  output logic [1:0]       out_tuser  // status
);
  dlf_s1_t s1_nxt, s1_r;
  dlf_s2_t s2_nxt, s2_r;
  dlf_out_t o_nxt, o_r;
  logic v1_r, v2_r, v3_r, adv;

  assign adv = !v3_r || out_tready;
  assign in_tready = adv;

  dlf_stage_decode u_dec (.mode(in_tuser), .operand(in_tdata), .s1(s1_nxt));
  dlf_stage_round  u_rnd (.s1(s1_r), .s2(s2_nxt));
  dlf_stage_pack   u_pck (.s2(s2_r), .o(o_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      o_r  <= o_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = o_r.res;
  assign out_tuser  = o_r.status;

  `DLF_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `DLF_ASSERT_IMP(a_ready, !out_tvalid, in_tready)
  `DLF_ASSERT_NEXT(a_flow, in_tvalid && in_tready, v1_r)
endmodule
`default_nettype wire
